// File: sv/console_root_counter_timer_core_macros.svh
// assertion macros for the checker file of the root counter timer
// no dependencies; each macro expects clk and rst_n in scope
`ifndef CONSOLE_ROOT_COUNTER_TIMER_CORE_MACROS_SVH
`define CONSOLE_ROOT_COUNTER_TIMER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CRCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/crct_pkg.sv
// types and constants of the root counter timer
// no dependencies; used by every module of the block
`default_nettype none

package crct_pkg;

  // command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_SYNC  = 2'd3
  } crct_cmd_t;

  // sync modes held in mode bits 2:1
  typedef enum logic [1:0] {
    SYNC_PAUSE  = 2'd0,
    SYNC_CLEAR  = 2'd1,
    SYNC_WINDOW = 2'd2,
    SYNC_ONCE   = 2'd3
  } crct_sync_t;

  // register offsets
  localparam logic [3:0] OFF_VALUE  = 4'd0;
  localparam logic [3:0] OFF_MODE   = 4'd4;
  localparam logic [3:0] OFF_TARGET = 4'd8;

  // mode word bit positions
  localparam int unsigned MB_SYNC_EN   = 0;
  localparam int unsigned MB_SYNC_LO   = 1;
  localparam int unsigned MB_SYNC_HI   = 2;
  localparam int unsigned MB_RESET_TGT = 3;
  localparam int unsigned MB_IRQ_TGT   = 4;
  localparam int unsigned MB_IRQ_OVF   = 5;
  localparam int unsigned MB_REPEAT    = 6;
  localparam int unsigned MB_TOGGLE    = 7;
  localparam int unsigned MB_SRC_LO    = 8;
  localparam int unsigned MB_SRC_HI    = 9;
  localparam int unsigned MB_IRQ_REQ   = 10;
  localparam int unsigned MB_HIT_TGT   = 11;
  localparam int unsigned MB_HIT_OVF   = 12;

  // serial divider sizes: dividend holds 11 times a 32-bit accumulator
  localparam int unsigned DVD_W = 36;
  localparam int unsigned DVS_W = 12;
  localparam int unsigned QUO_W = 16;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  // hblank clock divider and overflow limit
  localparam logic [DVS_W-1:0] HBLANK_DIV = 12'd2160;
  localparam logic [31:0]      OVF_LIMIT  = 32'h0000_ffff;

  // input transaction
  typedef struct packed {
    crct_cmd_t   cmd;
    logic [3:0]  reg_offset;
    logic [31:0] write_value;
    logic [15:0] tick_cycles;
    logic        hblank_level;
    logic        vblank_level;
    logic [3:0]  dot_divider_in;
  } crct_in_t;

  // result transaction
  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_pulse;
    logic        bad_access;
  } crct_out_t;

  // divider request and response
  typedef struct packed {
    logic             load;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } crct_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } crct_div_rsp_t;

endpackage

`default_nettype wire

// File: sv/crct_serdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on crct_pkg for sizes and request/response types
`default_nettype none

module crct_serdiv (
  input  wire                    clk,
  input  wire                    rst_n,
  input  crct_pkg::crct_div_req_t req,
  output crct_pkg::crct_div_rsp_t rsp
);
  import crct_pkg::*;

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W+1:0] trial;

  // trial subtract of the divisor from the partial remainder and next bit
  assign trial = {1'b0, rem_r, dvd_r[DVD_W-1]} - {2'b00, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.load) begin
      dvd_nxt = req.dividend;
      dvs_nxt = req.divisor;
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = CNT_W'(DVD_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift one dividend bit in, keep the difference when it did not borrow
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      if (!trial[DVS_W+1]) begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DVS_W-2:0], dvd_r[DVD_W-1]};
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

// File: sv/console_root_counter_timer_core.sv
// root counter timer: register file, tick sequencer and interrupt rules
// depends on crct_pkg and crct_serdiv
//
//   channel   ports                          handshake
//   input     start, busy, in_data           taken when start high and busy low
//   result    out_strobe, out_data           one cycle strobe, cannot be held off
//
// read, write and sync transactions give their result the cycle after they are taken.
// a tick passes the gate, add and compare states, or ends in gate when the blanking gate stops
// it; for a dividing dot clock or hblank source a divide state comes before add, where the
// serial divider produces one of its 36 quotient bits per cycle. busy is high from a tick's
// acceptance until its result strobe. synchronous active-low reset clears the state registers.
`default_nettype none

module console_root_counter_timer_core #(
  parameter int unsigned TIMER_INDEX = 0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  crct_pkg::crct_in_t  in_data,
  output logic                out_strobe,
  output crct_pkg::crct_out_t out_data
);
  import crct_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GATE = 5'b00010,
    S_DIV  = 5'b00100,
    S_ADD  = 5'b01000,
    S_CMP  = 5'b10000
  } crct_state_t;

  crct_state_t state_r, state_nxt;
  logic [31:0] counter_r, counter_nxt;
  logic [15:0] mode_r, mode_nxt;
  logic [15:0] target_r, target_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        osd_r, osd_nxt;
  logic        hb_now_r, hb_now_nxt, hb_before_r, hb_before_nxt;
  logic        vb_now_r, vb_now_nxt, vb_before_r, vb_before_nxt;
  logic [3:0]  dotdiv_r, dotdiv_nxt;
  logic [15:0] inc_r, inc_nxt;
  logic        out_strobe_r, out_strobe_nxt;
  crct_out_t   out_r, out_nxt;

  crct_div_req_t div_req;
  crct_div_rsp_t div_rsp;

  logic             gate_now, gate_before;
  logic             gate_go, gate_clr, gate_sync_off;
  logic [DVD_W-1:0] accum_ext, dot_prod;
  logic [DVS_W-1:0] dot_dvs;
  logic             hit_tgt, hit_ovf, want, req_lvl;
  logic [31:0]      cmp_counter;
  logic [15:0]      cmp_mode;
  logic             cmp_osd, cmp_irq;

  // serial divider for the dot clock and hblank sources
  crct_serdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // dot clock: floor(floor(11a/7)/d) equals floor(11a/(7d))
  assign accum_ext = {{(DVD_W-32){1'b0}}, accum_r};
  assign dot_prod  = (accum_ext << 3) + (accum_ext << 1) + accum_ext;
  assign dot_dvs   = ({{(DVS_W-4){1'b0}}, dotdiv_r} << 3) - {{(DVS_W-4){1'b0}}, dotdiv_r};

  assign gate_now    = (TIMER_INDEX == 0) ? hb_now_r    : vb_now_r;
  assign gate_before = (TIMER_INDEX == 0) ? hb_before_r : vb_before_r;

  // blanking gate according to sync mode
  always_comb begin
    gate_go       = 1'b1;
    gate_clr      = 1'b0;
    gate_sync_off = 1'b0;
    if (mode_r[MB_SYNC_EN]) begin
      if (TIMER_INDEX < 2) begin
        case (crct_sync_t'(mode_r[MB_SYNC_HI:MB_SYNC_LO]))
          SYNC_PAUSE: gate_go = !gate_now;
          SYNC_CLEAR: gate_clr = gate_now;
          SYNC_WINDOW: begin
            gate_clr = gate_now;
            gate_go  = gate_now;
          end
          default: begin
            gate_go       = !gate_before && gate_now;
            gate_sync_off = !gate_before && gate_now;
          end
        endcase
      end else begin
        gate_go = mode_r[MB_SYNC_HI] != mode_r[MB_SYNC_LO];
      end
    end
  end

  // target and overflow compare, then pulse/toggle and one-shot/repeat rules
  always_comb begin
    cmp_mode    = mode_r;
    cmp_osd     = osd_r;
    cmp_irq     = 1'b0;
    req_lvl     = 1'b0;
    hit_tgt     = counter_r >= {16'h0000, target_r};
    cmp_counter = (hit_tgt && mode_r[MB_RESET_TGT]) ? 32'h0 : counter_r;
    hit_ovf     = cmp_counter >= OVF_LIMIT;
    if (hit_tgt) cmp_mode[MB_HIT_TGT] = 1'b1;
    if (hit_ovf) cmp_mode[MB_HIT_OVF] = 1'b1;
    want = (hit_tgt && mode_r[MB_IRQ_TGT]) || (hit_ovf && mode_r[MB_IRQ_OVF]);
    if (want) begin
      req_lvl = mode_r[MB_TOGGLE] && !mode_r[MB_IRQ_REQ];
      cmp_mode[MB_IRQ_REQ] = req_lvl;
      if (!mode_r[MB_REPEAT]) begin
        if (!osd_r && !req_lvl) begin
          cmp_osd              = 1'b1;
          cmp_mode[MB_IRQ_REQ] = 1'b1;
          cmp_irq              = 1'b1;
        end
      end else begin
        cmp_mode[MB_IRQ_REQ] = 1'b1;
        cmp_irq              = 1'b1;
      end
    end
  end

  // transaction sequencer
  always_comb begin
    state_nxt      = state_r;
    counter_nxt    = counter_r;
    mode_nxt       = mode_r;
    target_nxt     = target_r;
    accum_nxt      = accum_r;
    osd_nxt        = osd_r;
    hb_now_nxt     = hb_now_r;
    hb_before_nxt  = hb_before_r;
    vb_now_nxt     = vb_now_r;
    vb_before_nxt  = vb_before_r;
    dotdiv_nxt     = dotdiv_r;
    inc_nxt        = inc_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    div_req.load     = 1'b0;
    div_req.dividend = (TIMER_INDEX == 0) ? dot_prod : accum_ext;
    div_req.divisor  = (TIMER_INDEX == 0) ? dot_dvs : HBLANK_DIV;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_data.cmd)
            CMD_READ: begin
              out_strobe_nxt = 1'b1;
              unique case (in_data.reg_offset)
                OFF_VALUE:  out_nxt.read_data = counter_r[15:0];
                OFF_MODE:   out_nxt.read_data = mode_r;
                OFF_TARGET: out_nxt.read_data = target_r;
                default:    out_nxt.bad_access = 1'b1;
              endcase
            end
            CMD_WRITE: begin
              out_strobe_nxt = 1'b1;
              unique case (in_data.reg_offset)
                OFF_VALUE: counter_nxt = in_data.write_value;
                OFF_MODE: begin
                  counter_nxt          = 32'h0;
                  mode_nxt             = in_data.write_value[15:0];
                  mode_nxt[MB_IRQ_REQ] = 1'b1;
                  osd_nxt              = 1'b0;
                end
                OFF_TARGET: target_nxt = in_data.write_value[15:0];
                default: ;
              endcase
            end
            CMD_TICK: begin
              accum_nxt = accum_r + {16'h0000, in_data.tick_cycles};
              state_nxt = S_GATE;
            end
            CMD_SYNC: begin
              out_strobe_nxt = 1'b1;
              hb_before_nxt  = hb_now_r;
              vb_before_nxt  = vb_now_r;
              hb_now_nxt     = in_data.hblank_level;
              vb_now_nxt     = in_data.vblank_level;
              dotdiv_nxt     = in_data.dot_divider_in;
            end
            default: ;
          endcase
        end
      end
      S_GATE: begin
        if (gate_clr) counter_nxt = 32'h0;
        if (gate_sync_off) mode_nxt[MB_SYNC_EN] = 1'b0;
        if (!gate_go) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else if (TIMER_INDEX == 0 && mode_r[MB_SRC_LO]) begin
          if (dotdiv_r == 4'd0) begin
            inc_nxt   = 16'h0;
            accum_nxt = 32'h0;
            state_nxt = S_ADD;
          end else begin
            div_req.load = 1'b1;
            state_nxt    = S_DIV;
          end
        end else if (TIMER_INDEX == 1 && mode_r[MB_SRC_LO]) begin
          div_req.load = 1'b1;
          state_nxt    = S_DIV;
        end else if (TIMER_INDEX >= 2 && mode_r[MB_SRC_HI]) begin
          // system clock over eight
          inc_nxt   = accum_r[18:3];
          accum_nxt = {29'h0, accum_r[2:0]};
          state_nxt = S_ADD;
        end else begin
          inc_nxt   = accum_r[15:0];
          accum_nxt = 32'h0;
          state_nxt = S_ADD;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          inc_nxt   = div_rsp.quotient;
          accum_nxt = (TIMER_INDEX == 1) ? {{(32-DVS_W){1'b0}}, div_rsp.remainder} : 32'h0;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        counter_nxt = counter_r + {16'h0000, inc_r};
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        counter_nxt       = cmp_counter;
        mode_nxt          = cmp_mode;
        osd_nxt           = cmp_osd;
        out_nxt.irq_pulse = cmp_irq;
        out_strobe_nxt    = 1'b1;
        state_nxt         = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // timer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      counter_r    <= '0;
      mode_r       <= '0;
      target_r     <= '0;
      accum_r      <= '0;
      osd_r        <= 1'b0;
      hb_now_r     <= 1'b0;
      hb_before_r  <= 1'b0;
      vb_now_r     <= 1'b0;
      vb_before_r  <= 1'b0;
      dotdiv_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      counter_r    <= counter_nxt;
      mode_r       <= mode_nxt;
      target_r     <= target_nxt;
      accum_r      <= accum_nxt;
      osd_r        <= osd_nxt;
      hb_now_r     <= hb_now_nxt;
      hb_before_r  <= hb_before_nxt;
      vb_now_r     <= vb_now_nxt;
      vb_before_r  <= vb_before_nxt;
      dotdiv_r     <= dotdiv_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    inc_r <= inc_nxt;
    out_r <= out_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

// File: sv/crct_chk.sv
// port-level checks of the root counter timer, bound to the top level
// depends on crct_pkg and the assertion macro header
`default_nettype none
`include "console_root_counter_timer_core_macros.svh"

module crct_chk (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input crct_pkg::crct_in_t  in_data,
  input wire                 out_strobe,
  input crct_pkg::crct_out_t out_data
);
  import crct_pkg::*;

  logic take_short, take_tick;

  assign take_short = start && !busy && (in_data.cmd != CMD_TICK);
  assign take_tick  = start && !busy && (in_data.cmd == CMD_TICK);

  // register and sync transactions answer in the next cycle
  `CRCT_ASSERT_NEXT(a_short_result, take_short, out_strobe && !busy, "short transaction lost")

  // a tick holds the input side until its result
  `CRCT_ASSERT_NEXT(a_tick_busy, take_tick, busy && !out_strobe, "tick did not hold busy")

  // a result never appears while a tick is still in flight
  `CRCT_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result while busy")

  // interrupt and read fields never mix in one result
  `CRCT_ASSERT_NOW(a_fields_apart, out_strobe && (out_data.irq_pulse || out_data.bad_access),
    out_data.read_data == 16'h0 && !(out_data.irq_pulse && out_data.bad_access),
    "mixed result fields")

endmodule

bind console_root_counter_timer_core crct_chk u_crct_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire
